// ----- hdl/qdc_pkg.sv -----
// Shared types, codes and constants of the quadrature detent counter.
package qdc_pkg;

  // Input function codes.
  typedef enum logic [1:0] {
    FUNC_SAMPLE  = 2'd0,
    FUNC_REPORT  = 2'd1,
    FUNC_OTHER   = 2'd2,
    FUNC_GET_REP = 2'd3
  } func_e;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_REVERSE = 2'd0,
    CFG_LIMIT   = 2'd1,
    CFG_DETENT  = 2'd2,
    CFG_UNUSED  = 2'd3
  } cfg_idx_e;

  // Work codes passed from the front to the back.
  typedef enum logic [1:0] {
    OP_STEP   = 2'd0,
    OP_REPORT = 2'd1,
    OP_EMPTY  = 2'd2,
    OP_GET    = 2'd3
  } op_e;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 7;
  localparam int unsigned LimitW   = 7;
  localparam int unsigned DetentW  = 4;
  localparam int unsigned QcW      = 5;
  localparam int unsigned DeltaW   = 8;
  localparam int unsigned SeqW     = 8;

  localparam logic              ReverseRst = 1'b0;
  localparam logic [LimitW-1:0]  LimitRst   = 7'd120;
  localparam logic [DetentW-1:0] DetentRst  = 4'd4;

  localparam int unsigned QueueDepthDef = 2;

  typedef struct packed {
    logic [1:0] func;
    logic       pin_a;
    logic       pin_b;
  } in_item_t;

  typedef struct packed {
    logic                     empty_res;
    logic signed [DeltaW-1:0] delta;
    logic [SeqW-1:0]          sequence_res;
  } out_item_t;

  typedef struct packed {
    op_e               op;
    logic signed [1:0] step;
  } qdc_entry_t;

  typedef struct packed {
    logic               reverse;
    logic [LimitW-1:0]  limit;
    logic [DetentW-1:0] detent;
  } qdc_cfg_t;

  // Quarter steps per transition, indexed by {previous pins, new pins}.
  localparam logic signed [1:0] StepTable [16] = '{
     2'sd0, -2'sd1,  2'sd1,  2'sd0,
     2'sd1,  2'sd0,  2'sd0, -2'sd1,
    -2'sd1,  2'sd0,  2'sd0,  2'sd1,
     2'sd0,  2'sd1, -2'sd1,  2'sd0
  };

endpackage

// ----- hdl/qdc_front.sv -----
// Front end: accepts items, tracks the pin pair and classifies work for the back end.
module qdc_front import qdc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  in_item_t   item_i,
  output logic       push_o,
  output qdc_entry_t entry_o
);

  logic [1:0] last_pins_q, last_pins_d;
  logic       seen_q, seen_d;
  logic [1:0] pins;

  assign pins = {item_i.pin_a, item_i.pin_b};

  always_comb begin
    last_pins_d   = last_pins_q;
    seen_d        = seen_q;
    push_o        = 1'b0;
    entry_o.op    = OP_STEP;
    entry_o.step  = StepTable[{last_pins_q, pins}];
    if (accept_i) begin
      unique case (func_e'(item_i.func))
        FUNC_SAMPLE: begin
          last_pins_d = pins;
          seen_d      = 1'b1;
          // first sample and unchanged pins cause no work
          push_o      = seen_q && (pins != last_pins_q);
        end
        FUNC_REPORT: begin
          push_o     = 1'b1;
          entry_o.op = OP_REPORT;
        end
        FUNC_OTHER: begin
          push_o     = 1'b1;
          entry_o.op = OP_EMPTY;
        end
        FUNC_GET_REP: begin
          push_o     = 1'b1;
          entry_o.op = OP_GET;
        end
        default: push_o = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_pins_q <= 2'b00;
      seen_q      <= 1'b0;
    end else begin
      last_pins_q <= last_pins_d;
      seen_q      <= seen_d;
    end
  end

endmodule

// ----- hdl/qdc_fifo.sv -----
// Short register queue between the front and back ends.
module qdc_fifo import qdc_pkg::*; #(
  parameter int unsigned Depth = QueueDepthDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  qdc_entry_t entry_i,
  output logic       full_o,
  output logic       valid_o,
  output qdc_entry_t entry_o,
  input  logic       pop_i
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  qdc_entry_t         mem_q [Depth];
  logic [PtrW-1:0]    wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]    count_q, count_d;
  logic               do_push, do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign valid_o = (count_q != '0);
  assign entry_o = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

// ----- hdl/qdc_back.sv -----
// Back end: quarter-step and detent counting, report generation and output register.
module qdc_back import qdc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  qdc_cfg_t   cfg_i,
  input  logic       valid_i,
  input  qdc_entry_t entry_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output out_item_t  out_item_o
);

  logic signed [QcW-1:0]    qc_q, qc_d, qc_sum, det, det_neg;
  logic signed [DeltaW-1:0] pend_q, pend_d, lim, lim_neg;
  logic [SeqW-1:0]          seq_q, seq_d;
  logic [DeltaW+SeqW-1:0]   last_q, last_d;
  logic                     ov_q, ov_d;
  out_item_t                out_q, out_d;
  logic                     out_free, up, dn, inc, dec;

  assign out_free = !ov_q || out_ready_i;
  assign pop_o    = valid_i && ((entry_i.op == OP_STEP) || out_free);

  assign qc_sum  = qc_q + $signed({{(QcW-2){entry_i.step[1]}}, entry_i.step});
  // zero detent acts as one
  assign det     = $signed({1'b0, (cfg_i.detent == '0) ? DetentW'(1) : cfg_i.detent});
  assign det_neg = -det;
  assign up      = (qc_sum >= det);
  assign dn      = (qc_sum <= det_neg);
  assign inc     = (up && !cfg_i.reverse) || (dn && cfg_i.reverse);
  assign dec     = (up && cfg_i.reverse) || (dn && !cfg_i.reverse);
  assign lim     = $signed({1'b0, cfg_i.limit});
  assign lim_neg = -lim;

  always_comb begin
    qc_d   = qc_q;
    pend_d = pend_q;
    seq_d  = seq_q;
    last_d = last_q;
    ov_d   = ov_q && !out_ready_i;
    out_d  = out_q;
    if (pop_o) begin
      unique case (entry_i.op)
        OP_STEP: begin
          qc_d = (up || dn) ? '0 : qc_sum;
          if (inc && (pend_q < lim)) begin
            pend_d = pend_q + 1'b1;
          end else if (dec && (pend_q > lim_neg)) begin
            pend_d = pend_q - 1'b1;
          end
        end
        OP_REPORT: begin
          pend_d             = '0;
          seq_d              = seq_q + 1'b1;
          last_d             = {seq_q, pend_q};
          ov_d               = 1'b1;
          out_d.empty_res    = 1'b0;
          out_d.delta        = pend_q;
          out_d.sequence_res = seq_q;
        end
        OP_EMPTY: begin
          ov_d               = 1'b1;
          out_d.empty_res    = 1'b1;
          out_d.delta        = '0;
          out_d.sequence_res = '0;
        end
        OP_GET: begin
          ov_d               = 1'b1;
          out_d.empty_res    = 1'b0;
          out_d.delta        = $signed(last_q[DeltaW-1:0]);
          out_d.sequence_res = last_q[DeltaW+SeqW-1:DeltaW];
        end
        default: ov_d = ov_q && !out_ready_i;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qc_q   <= '0;
      pend_q <= '0;
      seq_q  <= '0;
      last_q <= '0;
      ov_q   <= 1'b0;
    end else begin
      qc_q   <= qc_d;
      pend_q <= pend_d;
      seq_q  <= seq_d;
      last_q <= last_d;
      ov_q   <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = ov_q;
  assign out_item_o  = out_q;

endmodule

// ----- hdl/quadrature_detent_counter.sv -----
// Top level of the quadrature detent counter with polled relative report.
//
//   channel  direction  handshake                 payload
//   in       input      in_valid_i / in_ready_o   in_item_i (func, pin_a, pin_b)
//   out      output     out_valid_o / out_ready_i out_item_o (empty_res, delta, sequence_res)
//   cfg      input      cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// One item per cycle sustained while the queue has room. A poll result
// passes through the queue entry, written at the accepting edge, and then
// the output register, written once the back end can retire it.
// Reset clears all counters, the last report and the queue.
// A stalled output holds its result while the queue keeps taking items; the
// input stalls only when the queue is full.
module quadrature_detent_counter import qdc_pkg::*; #(
  parameter int unsigned QueueDepth = QueueDepthDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  in_item_t            in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output out_item_t           out_item_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  qdc_cfg_t   cfg_q, cfg_d;
  logic       in_accept, push, full, q_valid, pop;
  qdc_entry_t push_entry, head_entry;

  // Configuration is always writable; unknown indexes are dropped.
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_REVERSE: cfg_d.reverse = cfg_data_i[0];
        CFG_LIMIT:   cfg_d.limit   = cfg_data_i[LimitW-1:0];
        CFG_DETENT:  cfg_d.detent  = cfg_data_i[DetentW-1:0];
        CFG_UNUSED:  cfg_d         = cfg_q;
        default:     cfg_d         = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.reverse <= ReverseRst;
      cfg_q.limit   <= LimitRst;
      cfg_q.detent  <= DetentRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Front takes an item whenever the queue has room.
  assign in_ready_o = !full;
  assign in_accept  = in_valid_i && in_ready_o;

  qdc_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (in_accept),
    .item_i   (in_item_i),
    .push_o   (push),
    .entry_o  (push_entry)
  );

  qdc_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .full_o  (full),
    .valid_o (q_valid),
    .entry_o (head_entry),
    .pop_i   (pop)
  );

  // Back end retires step work every cycle, poll work when the output frees.
  qdc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .valid_i     (q_valid),
    .entry_i     (head_entry),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule

// ----- sim/tb.sv -----
// Self-checking testbench for the quadrature detent counter.
module tb;
  import qdc_pkg::*;

  // Clock, reset and DUT pins. Every input starts at a known value.
  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_ready_o;
  in_item_t            in_item_i   = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  out_item_t           out_item_o;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i  = '0;

  quadrature_detent_counter i_dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .in_item_i,
    .out_valid_o,
    .out_ready_i,
    .out_item_o,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_index_i,
    .cfg_data_i
  );

  always #10 clk_i = ~clk_i;

  // Items waiting to be driven, and results owed by the DUT, oldest first.
  in_item_t  input_items[$];
  out_item_t expected_reports[$];

  // Pacing knobs, percent of cycles spent idle/stalled.
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;

  // Predictor copy of the registers.
  logic              cfg_reverse = ReverseRst;
  logic [LimitW-1:0]  cfg_limit   = LimitRst;
  logic [DetentW-1:0] cfg_detent  = DetentRst;

  // Predictor copy of the counter state.
  logic [1:0]  prev_pins     = 2'b00;
  logic        pins_valid    = 1'b0;
  int          qtr_acc       = 0;
  int          detent_delta  = 0;
  logic [7:0]  report_seq    = 8'd0;
  out_item_t   last_report   = '0;

  // Bookkeeping for the summary and the verdict.
  int n_items = 0, n_reports = 0, n_empty = 0, n_rereads = 0;
  int n_detents = 0, n_clamped = 0, n_checked = 0, n_cfg = 0;
  int errors = 0;

  // Generator-side position on the gray cycle 00 -> 10 -> 11 -> 01.
  int gen_pos = 0;

  // Position of a pin pair on the forward gray cycle.
  function automatic int gray_pos(logic [1:0] p);
    case (p)
      2'b00:   return 0;
      2'b10:   return 1;
      2'b11:   return 2;
      default: return 3;
    endcase
  endfunction

  function automatic logic [1:0] gray_pins(int pos);
    case (pos & 3)
      0:       return 2'b00;
      1:       return 2'b10;
      2:       return 2'b11;
      default: return 2'b01;
    endcase
  endfunction

  // One forward neighbor step counts +1, one backward -1; staying put or
  // jumping across the cycle (both phases flipped) counts nothing.
  function automatic int quarter_move(logic [1:0] from, logic [1:0] to);
    int d;
    d = (gray_pos(to) - gray_pos(from)) & 3;
    if (d == 1) return 1;
    if (d == 3) return -1;
    return 0;
  endfunction

  // Register write as the DUT sees it; index 3 is unmapped.
  task automatic apply_cfg(cfg_idx_e idx, logic [CfgDataW-1:0] val);
    case (idx)
      CFG_REVERSE: cfg_reverse = val[0];
      CFG_LIMIT:   cfg_limit   = val[LimitW-1:0];
      CFG_DETENT:  cfg_detent  = val[DetentW-1:0];
      default: ;
    endcase
    n_cfg++;
  endtask

  // Predictor: advance the state for one accepted item and queue the
  // result it owes, if any.
  task automatic decode_item(in_item_t it);
    logic [1:0] pins;
    int         det;
    int         dir;
    out_item_t  res;
    pins = {it.pin_a, it.pin_b};
    n_items++;
    case (it.func)
      FUNC_SAMPLE: begin
        if (!pins_valid) begin
          // very first sample only latches the pair
          prev_pins  = pins;
          pins_valid = 1'b1;
        end else if (pins != prev_pins) begin
          qtr_acc += quarter_move(prev_pins, pins);
          prev_pins = pins;
          det = (cfg_detent == 0) ? 1 : int'(cfg_detent);
          dir = 0;
          if (qtr_acc >= det) dir = 1;
          else if (qtr_acc <= -det) dir = -1;
          if (dir != 0) begin
            qtr_acc = 0;
            n_detents++;
            if (cfg_reverse) dir = -dir;
            // clamp only blocks a move further out; a value past a lowered
            // limit stays until it walks back
            if (dir > 0 && detent_delta < int'(cfg_limit)) detent_delta++;
            else if (dir < 0 && detent_delta > -int'(cfg_limit)) detent_delta--;
            else n_clamped++;
          end
        end
      end
      FUNC_REPORT: begin
        res.empty_res    = 1'b0;
        res.delta        = detent_delta[7:0];
        res.sequence_res = report_seq;
        last_report      = res;
        detent_delta     = 0;
        report_seq++;
        expected_reports.push_back(res);
        n_reports++;
      end
      FUNC_OTHER: begin
        res = '0;
        res.empty_res = 1'b1;
        expected_reports.push_back(res);
        n_empty++;
      end
      default: begin
        expected_reports.push_back(last_report);
        n_rereads++;
      end
    endcase
  endtask

  // Input driver: holds valid and payload until taken, idles at random
  // while the channel is free.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_item_i  <= '0;
    end else begin
      if (in_valid_i && in_ready_o) decode_item(in_item_i);
      if (!in_valid_i || in_ready_o) begin
        if (input_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid_i <= 1'b1;
          in_item_i  <= input_items.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Output monitor: random backpressure, each taken result checked against
  // the oldest expectation field by field.
  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t exp_res;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (expected_reports.size() == 0) begin
          errors++;
          $display("%0t: unexpected result empty=%0b delta=%0d seq=%0d", $time,
                   out_item_o.empty_res, out_item_o.delta, out_item_o.sequence_res);
        end else begin
          exp_res = expected_reports.pop_front();
          n_checked++;
          if (out_item_o.empty_res !== exp_res.empty_res) begin
            errors++;
            $display("%0t: empty_res expected %0b got %0b", $time,
                     exp_res.empty_res, out_item_o.empty_res);
          end
          if (out_item_o.delta !== exp_res.delta) begin
            errors++;
            $display("%0t: delta expected %0d got %0d", $time,
                     exp_res.delta, out_item_o.delta);
          end
          if (out_item_o.sequence_res !== exp_res.sequence_res) begin
            errors++;
            $display("%0t: sequence_res expected %0d got %0d", $time,
                     exp_res.sequence_res, out_item_o.sequence_res);
          end
        end
      end
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Queue one item; pins of non-sample items are don't-care, so add_poll randomizes them.
  task automatic add_item(func_e f, logic [1:0] pins);
    in_item_t it;
    it.func  = f;
    it.pin_a = pins[1];
    it.pin_b = pins[0];
    input_items.push_back(it);
  endtask

  task automatic add_sample(logic [1:0] pins);
    add_item(FUNC_SAMPLE, pins);
    gen_pos = gray_pos(pins);
  endtask

  task automatic add_poll(func_e f);
    add_item(f, 2'($urandom_range(3)));
  endtask

  // Wait until everything queued was taken and answered, then let the pipe
  // settle since samples leave no result to wait on.
  task automatic wait_drained();
    do @(posedge clk_i);
    while (input_items.size() != 0 || in_valid_i || expected_reports.size() != 0);
    repeat (6) @(posedge clk_i);
  endtask

  // Write all registers back to back (plus the unmapped index), valid held
  // high across the burst.
  task automatic program_cfg(logic rev, logic [CfgDataW-1:0] lim,
                             logic [CfgDataW-1:0] det);
    cfg_idx_e            idx[4];
    logic [CfgDataW-1:0] val[4];
    idx[0] = CFG_REVERSE; val[0] = {6'($urandom), rev};
    idx[1] = CFG_LIMIT;   val[1] = lim;
    idx[2] = CFG_DETENT;  val[2] = det;
    idx[3] = CFG_UNUSED;  val[3] = 7'($urandom);
    for (int i = 0; i < 4; i++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= idx[i];
      cfg_data_i  <= val[i];
      do @(posedge clk_i); while (!cfg_ready_o);
      apply_cfg(idx[i], val[i]);
    end
    cfg_valid_i <= 1'b0;
  endtask

  // Random traffic: mostly clean rotation bursts in one direction, with
  // host polls mixed in and some noise (repeats, random pairs, jumps).
  task automatic add_random(int n, int poll_pct);
    int cnt;
    int r;
    int len;
    int dir;
    cnt = 0;
    while (cnt < n) begin
      r = $urandom_range(99);
      if (r < poll_pct) begin
        add_poll(FUNC_REPORT);
        cnt++;
      end else if (r < poll_pct + 4) begin
        add_poll(FUNC_GET_REP);
        cnt++;
      end else if (r < poll_pct + 8) begin
        add_poll(FUNC_OTHER);
        cnt++;
      end else if (r < poll_pct + 13) begin
        add_sample(gray_pins(gen_pos));
        cnt++;
      end else if (r < poll_pct + 18) begin
        add_sample(2'($urandom_range(3)));
        cnt++;
      end else begin
        len = $urandom_range(1, 20);
        dir = $urandom_range(1) ? 1 : -1;
        repeat (len) add_sample(gray_pins(gen_pos + dir));
        cnt += len;
      end
    end
  endtask

  task automatic run_phase(logic rev, logic [CfgDataW-1:0] lim,
                           logic [CfgDataW-1:0] det, int unsigned send_pct,
                           int unsigned recv_pct, int n, int poll_pct);
    program_cfg(rev, lim, det);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    add_random(n, poll_pct);
    wait_drained();
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part at reset settings (forward, limit 120, 4 per detent).
    add_poll(FUNC_GET_REP);    // re-read before any report: all zero
    add_poll(FUNC_OTHER);
    add_poll(FUNC_REPORT);     // nothing pending, sequence 0
    add_sample(2'b11);         // first sample only latches
    add_sample(2'b11);         // unchanged pair
    add_sample(2'b01);
    add_sample(2'b00);
    add_sample(2'b10);
    add_sample(2'b11);         // fourth forward quarter: one detent up
    add_sample(2'b00);         // both phases flipped: no count
    add_sample(2'b01);
    add_sample(2'b11);
    add_sample(2'b10);
    add_sample(2'b00);         // four back: one detent down, back to zero
    add_poll(FUNC_REPORT);
    add_sample(2'b10);
    add_sample(2'b11);
    add_sample(2'b01);
    add_sample(2'b00);
    add_poll(FUNC_REPORT);     // delta +1
    add_poll(FUNC_GET_REP);    // same report again
    add_sample(2'b11);         // invalid jump
    add_poll(FUNC_OTHER);
    // Hold the sender until every answer is back before going on.
    wait_drained();

    // Register sweeps; pacing cycles through free-running, sender idle,
    // receiver stalling and both.
    run_phase(1'b0, 7'd120, 7'd1,   59,  0, 170, 12);
    run_phase(1'b1, 7'd1,   7'd8,    0, 59, 170, 12);
    // Rare polls with 1 quarter per detent: pushes the delta into the clamp.
    run_phase(1'b0, 7'd127, 7'd1,   19, 19, 200,  1);
    // Lowered limit with a large delta left over; zero detent acts as one.
    run_phase(1'b1, 7'd5,   7'd0,    0,  0, 150, 10);
    // Zero limit; detent data with upper bits set selects 15.
    run_phase(1'b0, 7'd0,   7'h7F,  59,  0, 120, 10);
    run_phase(1'($urandom), 7'($urandom), 7'($urandom_range(0, 8)),
              0, 59, 150, 12);
    run_phase(1'($urandom), 7'($urandom_range(1, 127)), 7'($urandom),
              19, 19, 150, 12);

    if (expected_reports.size() != 0) begin
      errors++;
      $display("%0t: %0d results never arrived", $time, expected_reports.size());
    end
    $display("Ran %0d items over %0d register writes: %0d reports, %0d empty, %0d re-reads",
             n_items, n_cfg, n_reports, n_empty, n_rereads);
    $display("Saw %0d detents (%0d held by the limit), %0d results checked, %0d errors",
             n_detents, n_clamped, n_checked, errors);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin
    #4000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/qdc_pkg.sv
hdl/qdc_front.sv
hdl/qdc_fifo.sv
hdl/qdc_back.sv
hdl/quadrature_detent_counter.sv
sim/tb.sv
